// ===== hdl/gdge_pkg.sv =====
// Shared types and constants of the grid diffusion and gradient engine.
package gdge_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned SUM_W   = 18;
	localparam int unsigned D4_W    = 19;
	localparam int unsigned RATE_W  = 17;
	localparam int unsigned PROD_W  = 37;
	localparam int unsigned CHG_W   = 20;
	localparam int unsigned VAL_W   = 21;
	localparam int unsigned RATE_SH = 18;
	localparam int unsigned GEOM_W  = 7;
	localparam logic [RATE_W-1:0] ONE_RATE  = 17'h10000;
	localparam logic [DATA_W-1:0] ONE_VALUE = 16'h8000;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_DIFF  = 2'd1,
		CMD_GRAD  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RATE   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		RS_HOST,
		RS_C,
		RS_N,
		RS_S,
		RS_W,
		RS_E
	} rsel_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_OLD,
		CAP_SUM0,
		CAP_SUMADD,
		CAP_E,
		CAP_W,
		CAP_S,
		CAP_N
	} cap_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_D_OLD,
		ST_D_N,
		ST_D_S,
		ST_D_W,
		ST_D_E,
		ST_D_LAST,
		ST_D_DIFF,
		ST_D_MUL,
		ST_D_WR,
		ST_G_E,
		ST_G_W,
		ST_G_S,
		ST_G_N,
		ST_G_LAST,
		ST_G_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		rsel_t rd_sel;
		cap_t  cap;
		logic  host_we;
		logic  host_acc;
		logic  dif_we;
		logic  grd_we;
		logic  clr_we;
		logic  cnt_init;
		logic  cnt_step;
		logic  d4_en;
		logic  mul_en;
		logic  out_zero;
		logic  out_read;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic elem_last;
		logic small_grid;
	} dp_stat_t;

endpackage

// ===== hdl/gdge_ctrl.sv =====
// Controller state machine of the grid diffusion and gradient engine.
module gdge_ctrl
	import gdge_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic [1:0]   command,
	output logic         s_tready,
	input  dp_stat_t     stat,
	output dp_cmd_t      cmd
);

	state_t state_q, state_nx;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_code_t'(command))
						CMD_WRITE: state_nx = ST_IDLE;
						CMD_READ:  state_nx = ST_RD_WAIT;
						CMD_DIFF:  state_nx = stat.small_grid ? ST_DONE : ST_D_OLD;
						CMD_GRAD:  state_nx = stat.small_grid ? ST_DONE : ST_G_E;
						default:   state_nx = ST_IDLE;
					endcase
				end
			end
			ST_RD_WAIT: state_nx = ST_IDLE;
			ST_D_OLD:   state_nx = ST_D_N;
			ST_D_N:     state_nx = ST_D_S;
			ST_D_S:     state_nx = ST_D_W;
			ST_D_W:     state_nx = ST_D_E;
			ST_D_E:     state_nx = ST_D_LAST;
			ST_D_LAST:  state_nx = ST_D_DIFF;
			ST_D_DIFF:  state_nx = ST_D_MUL;
			ST_D_MUL:   state_nx = ST_D_WR;
			ST_D_WR:    state_nx = stat.elem_last ? ST_DONE : ST_D_OLD;
			ST_G_E:     state_nx = ST_G_W;
			ST_G_W:     state_nx = ST_G_S;
			ST_G_S:     state_nx = ST_G_N;
			ST_G_N:     state_nx = ST_G_LAST;
			ST_G_LAST:  state_nx = ST_G_WR;
			ST_G_WR:    state_nx = stat.elem_last ? ST_DONE : ST_G_E;
			ST_DONE: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RS_HOST;
		cmd.cap    = CAP_NONE;
		unique case (state_q)
			ST_CLEAR: cmd.clr_we = 1'b1;
			ST_IDLE: begin
				if (accept) begin
					cmd.host_acc = 1'b1;
					unique case (cmd_code_t'(command))
						CMD_WRITE: begin
							cmd.host_we  = 1'b1;
							cmd.out_zero = 1'b1;
						end
						CMD_READ:  cmd.rd_sel = RS_HOST;
						CMD_DIFF,
						CMD_GRAD:  cmd.cnt_init = 1'b1;
						default:   cmd.host_acc = 1'b1;
					endcase
				end
			end
			ST_RD_WAIT: cmd.out_read = 1'b1;
			ST_D_OLD:   cmd.rd_sel = RS_C;
			ST_D_N: begin
				cmd.rd_sel = RS_N;
				cmd.cap    = CAP_OLD;
			end
			ST_D_S: begin
				cmd.rd_sel = RS_S;
				cmd.cap    = CAP_SUM0;
			end
			ST_D_W: begin
				cmd.rd_sel = RS_W;
				cmd.cap    = CAP_SUMADD;
			end
			ST_D_E: begin
				cmd.rd_sel = RS_E;
				cmd.cap    = CAP_SUMADD;
			end
			ST_D_LAST:  cmd.cap = CAP_SUMADD;
			ST_D_DIFF:  cmd.d4_en = 1'b1;
			ST_D_MUL:   cmd.mul_en = 1'b1;
			ST_D_WR: begin
				cmd.dif_we   = 1'b1;
				cmd.cnt_step = 1'b1;
			end
			ST_G_E:     cmd.rd_sel = RS_E;
			ST_G_W: begin
				cmd.rd_sel = RS_W;
				cmd.cap    = CAP_E;
			end
			ST_G_S: begin
				cmd.rd_sel = RS_S;
				cmd.cap    = CAP_W;
			end
			ST_G_N: begin
				cmd.rd_sel = RS_N;
				cmd.cap    = CAP_S;
			end
			ST_G_LAST:  cmd.cap = CAP_N;
			ST_G_WR: begin
				cmd.grd_we   = 1'b1;
				cmd.cnt_step = 1'b1;
			end
			ST_DONE:    cmd.out_zero = stat.out_free;
			default:    cmd.cap = CAP_NONE;
		endcase
	end

endmodule

// ===== hdl/gdge_datapath.sv =====
// Datapath of the grid diffusion and gradient engine: stores, counters, arithmetic, output.
module gdge_datapath
	import gdge_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int CHANNELS   = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [5:0]          col,
	input  logic [5:0]          row,
	input  logic [1:0]          chan,
	input  logic [DATA_W-1:0]   cell_value,
	input  logic [GEOM_W-1:0]   grid_width,
	input  logic [GEOM_W-1:0]   grid_height,
	input  logic [RATE_W-1:0]   diffusion_rate,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int XCW   = $clog2(MAX_WIDTH + 128);
	localparam int YCW   = $clog2(MAX_HEIGHT + 128);
	localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH * CHANNELS);
	localparam logic [AW-1:0] COL_STEP = AW'(CHANNELS);

	logic [DATA_W-1:0] ch_mem [DEPTH];
	logic [DATA_W-1:0] gx_mem [DEPTH];
	logic [DATA_W-1:0] gy_mem [DEPTH];

	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;
	logic [CHW-1:0]    c_q;
	logic [AW-1:0]     clr_q;
	logic [XCW-1:0]    w_used;
	logic [YCW-1:0]    h_used;
	logic [RATE_W-1:0] rate_sat;
	logic              x_last, y_last, c_last;
	logic [AW-1:0]     center, host_idx, rd_addr;
	logic              host_ok, host_ok_q;
	logic [DATA_W-1:0] ch_rd_q, gx_rd_q, gy_rd_q;
	logic [DATA_W-1:0] old_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0] ge_q, gw_q, gs_q, gn_q;
	logic signed [D4_W-1:0]   d4_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0]        mag;
	logic signed [CHG_W-1:0]  chg;
	logic signed [VAL_W-1:0]  vsum;
	logic [DATA_W-1:0]        vnew;
	logic signed [DATA_W:0]   dx, dy;
	logic signed [DATA_W:0]   hx, hy;
	logic              out_valid_q;
	logic [47:0]       out_data_q;

	assign w_used   = (XCW'(grid_width) > XCW'(MAX_WIDTH)) ? XCW'(MAX_WIDTH)
	                                                       : XCW'(grid_width);
	assign h_used   = (YCW'(grid_height) > YCW'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT)
	                                                         : YCW'(grid_height);
	assign rate_sat = (diffusion_rate > ONE_RATE) ? ONE_RATE : diffusion_rate;

	assign x_last = (XCW'(x_q) == w_used - XCW'(2));
	assign y_last = (YCW'(y_q) == h_used - YCW'(2));
	assign c_last = (32'(c_q) == 32'(CHANNELS - 1));

	assign stat.elem_last  = x_last && y_last && c_last;
	assign stat.small_grid = (w_used < XCW'(3)) || (h_used < YCW'(3));
	assign stat.clr_last   = (32'(clr_q) == 32'(DEPTH - 1));
	assign stat.out_free   = !out_valid_q || m_tready;

	assign center   = AW'((AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q)) * COL_STEP) + AW'(c_q);
	assign host_idx = AW'((AW'(row) * AW'(MAX_WIDTH) + AW'(col)) * COL_STEP) + AW'(chan);
	assign host_ok  = (32'(col) < 32'(MAX_WIDTH)) && (32'(row) < 32'(MAX_HEIGHT))
	                  && (32'(chan) < 32'(CHANNELS));

	always_comb begin
		case (cmd.rd_sel)
			RS_C:    rd_addr = center;
			RS_N:    rd_addr = center - ROW_STEP;
			RS_S:    rd_addr = center + ROW_STEP;
			RS_W:    rd_addr = center - COL_STEP;
			RS_E:    rd_addr = center + COL_STEP;
			default: rd_addr = host_idx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			c_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_we) clr_q <= clr_q + AW'(1);
			if (cmd.cnt_init) begin
				x_q <= XW'(1);
				y_q <= YW'(1);
				c_q <= '0;
			end else if (cmd.cnt_step) begin
				if (c_last) begin
					c_q <= '0;
					if (x_last) begin
						x_q <= XW'(1);
						y_q <= y_q + YW'(1);
					end else begin
						x_q <= x_q + XW'(1);
					end
				end else begin
					c_q <= c_q + CHW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dif_we) begin
			ch_mem[center] <= vnew;
		end else if (cmd.host_we && host_ok) begin
			ch_mem[host_idx] <= cell_value;
		end
		ch_rd_q <= ch_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			gx_mem[clr_q] <= '0;
			gy_mem[clr_q] <= '0;
		end else if (cmd.grd_we) begin
			gx_mem[center] <= hx[DATA_W-1:0];
			gy_mem[center] <= hy[DATA_W-1:0];
		end
		gx_rd_q <= gx_mem[rd_addr];
		gy_rd_q <= gy_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.host_acc) host_ok_q <= host_ok;
		case (cmd.cap)
			CAP_OLD:    old_q <= ch_rd_q;
			CAP_SUM0:   sum_q <= SUM_W'(ch_rd_q);
			CAP_SUMADD: sum_q <= sum_q + SUM_W'(ch_rd_q);
			CAP_E:      ge_q  <= ch_rd_q;
			CAP_W:      gw_q  <= ch_rd_q;
			CAP_S:      gs_q  <= ch_rd_q;
			CAP_N:      gn_q  <= ch_rd_q;
			default:    old_q <= old_q;
		endcase
		if (cmd.d4_en) begin
			d4_s1 <= signed'({1'b0, sum_q}) - signed'({1'b0, old_q, 2'b00});
		end
		if (cmd.mul_en) begin
			prod_s2 <= PROD_W'(d4_s1) * PROD_W'(signed'({1'b0, rate_sat}));
		end
	end

	always_comb begin
		mag  = prod_s2[PROD_W-1] ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
		chg  = prod_s2[PROD_W-1] ? -signed'(CHG_W'(mag >> RATE_SH))
		                         : signed'(CHG_W'(mag >> RATE_SH));
		vsum = signed'(VAL_W'({1'b0, old_q})) + VAL_W'(chg);
		if (vsum < 0) begin
			vnew = '0;
		end else if (vsum > signed'(VAL_W'(ONE_VALUE))) begin
			vnew = ONE_VALUE;
		end else begin
			vnew = vsum[DATA_W-1:0];
		end
	end

	always_comb begin
		dx = signed'({1'b0, ge_q}) - signed'({1'b0, gw_q});
		dy = signed'({1'b0, gs_q}) - signed'({1'b0, gn_q});
		hx = (dx + (DATA_W+1)'(dx[DATA_W])) >>> 1;
		hy = (dy + (DATA_W+1)'(dy[DATA_W])) >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_zero || cmd.out_read) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_zero) begin
			out_data_q <= '0;
		end else if (cmd.out_read) begin
			out_data_q <= host_ok_q ? {gy_rd_q, gx_rd_q, ch_rd_q} : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hdl/grid_diffusion_gradient_engine_top.sv =====
// Top level of the grid diffusion and gradient engine: register port and stream channels.
//
// Commands arrive on the s_ stream: command in s_tuser, cell address and value in s_tdata.
// Every command returns one transaction on the m_ stream: read_value, slope_x, slope_y,
// all zero except for an in-range read cell.
// Write cell stores the value on acceptance; a write may follow in the next cycle if m_tready.
// Read cell reads the stores into their read registers, then loads the output register.
// A diffusion pass steps through ST_D_OLD to ST_D_WR for each interior cell channel, a
// gradient pass through ST_G_E to ST_G_WR, over (W-2)*(H-2)*CHANNELS cell channels, and
// ST_DONE posts the result; both are bound by the single read port of the value store.
// After reset the gradient stores are cleared one entry a cycle, all
// MAX_WIDTH*MAX_HEIGHT*CHANNELS entries (12288 at defaults), while s_tready is low.
// Write registers on the APB port only while no command is in flight; a pass reads the
// geometry registers on every cell.
// The output register holds a result until m_tready; a new command is taken only when
// that register is empty or drains in the same cycle, so a stalled receiver stalls input.
module grid_diffusion_gradient_engine_top
	import gdge_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int CHANNELS   = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // col, row, chan, cell_value, zero pad
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // read_value, slope_x, slope_y
);

	logic [GEOM_W-1:0] grid_width_q, grid_height_q;
	logic [RATE_W-1:0] diffusion_rate_q;
	logic              cfg_we;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q     <= GEOM_W'(64);
			grid_height_q    <= GEOM_W'(64);
			diffusion_rate_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:  grid_width_q     <= pwdata[GEOM_W-1:0];
				REG_HEIGHT: grid_height_q    <= pwdata[GEOM_W-1:0];
				REG_RATE:   diffusion_rate_q <= pwdata[RATE_W-1:0];
				default:    grid_width_q     <= grid_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:  prdata = 32'(grid_width_q);
			REG_HEIGHT: prdata = 32'(grid_height_q);
			REG_RATE:   prdata = 32'(diffusion_rate_q);
			default:    prdata = '0;
		endcase
	end

	gdge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gdge_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CHANNELS   (CHANNELS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.col            (s_tdata[5:0]),
		.row            (s_tdata[11:6]),
		.chan           (s_tdata[13:12]),
		.cell_value     (s_tdata[29:14]),
		.grid_width     (grid_width_q),
		.grid_height    (grid_height_q),
		.diffusion_rate (diffusion_rate_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule
